### design/sha_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-256 message hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package sha_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned BLOCK_BITS = 512;
   localparam int unsigned TOTAL_BITS = 61;

   localparam logic [5:0] LAST_FILL  = 6'd63;
   localparam logic [5:0] PAD_LIMIT  = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        length_error;
   } rsp_payload_type;

   typedef struct packed {
      logic       absorb;
      logic       overflow_set;
      logic       pad_shift;
      logic       pad_mark;
      logic       pad_len;
      logic       load_work;
      logic       round;
      logic       finalize;
      logic       restart;
      logic [5:0] round_idx;
      logic [2:0] word_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       total_max;
   } ctl_status_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### design/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 message hasher top level: controller plus datapath.
// Depends on sha_pkg, sha_controller and sha_datapath.
//
// Usage: the req channel carries one transaction per item: an optional message
// byte (byte_valid) and an end-of-message mark. The rsp channel delivers the
// eight digest words, word 0 first, with last_word on the eighth and the sticky
// length error flag on every word. Both channels use valid/stall.
// A transaction with a byte is taken while req_stall is low. The byte that
// completes a 64-byte block holds req_stall high through 64 rounds of the single
// round unit, one round per cycle, and then a step that adds into the hash words.
// No new byte is taken until that block is finished.
// After an end mark, padding shifts in one byte per cycle up to the end of the
// block (one or two blocks, each followed by its compression), then the digest
// words appear one per cycle while rsp_stall is low; a stalled word holds.
// Input is stalled from the end mark until the last digest word is taken, and
// the hasher then starts a new message. Synchronous reset loads the initial hash
// values and clears the length and fill counters; no clearing pass is needed.
module sha256_message_hasher (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sha_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sha_pkg::rsp_payload_type rsp_payload
);
   import sha_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   sha_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   sha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_byte    (req_payload.data_byte),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

### design/sha_datapath.sv
`timescale 1ns / 1ps
// Datapath of the SHA-256 hasher: block shift register, message schedule,
// round registers, hash words and length counter. Depends on sha_pkg.
module sha_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_byte,
   input  sha_pkg::ctl_cmd_type     cmd,
   output sha_pkg::ctl_status_type  status,
   output sha_pkg::rsp_payload_type rsp_payload
);
   import sha_pkg::*;

   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [31:0]           hash_ff [8];
   logic [31:0]           hash_in [8];
   logic [31:0]           work_ff [8];
   logic [31:0]           work_in [8];
   logic [5:0]            fill_ff, fill_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  ovf_ff, ovf_in;

   logic [7:0][7:0] len_bytes;
   logic [7:0]      pad_byte;
   logic [7:0]      shift_byte;
   logic [31:0]     w_new;
   logic [31:0]     t1;
   logic [31:0]     t2;

   assign len_bytes = {total_ff, 3'b000};

   always_comb begin
      pad_byte = '0;
      if (cmd.pad_mark) begin
         pad_byte = PAD_MARK;
      end else if (cmd.pad_len) begin
         // Bit length goes out most significant byte first over the last eight slots.
         pad_byte = len_bytes[~fill_ff[2:0]];
      end
      shift_byte = cmd.absorb ? req_byte : pad_byte;

      // The oldest schedule word sits at the top of the block register.
      w_new = small_sigma1(blk_ff[63 -: 32]) + blk_ff[223 -: 32]
            + small_sigma0(blk_ff[479 -: 32]) + blk_ff[511 -: 32];

      t1 = work_ff[7] + big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + ROUND_K[cmd.round_idx] + blk_ff[511 -: 32];
      t2 = big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));

      blk_in   = blk_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;

      if (cmd.absorb || cmd.pad_shift) begin
         blk_in  = {blk_ff[BLOCK_BITS-9:0], shift_byte};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.round) begin
         blk_in = {blk_ff[BLOCK_BITS-WORD_BITS-1:0], w_new};
      end
      if (cmd.absorb) begin
         total_in = total_ff + TOTAL_BITS'(1);
      end
      if (cmd.overflow_set) begin
         ovf_in = 1'b1;
      end

      if (cmd.load_work) begin
         work_in = hash_ff;
      end else if (cmd.round) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end

      if (cmd.finalize) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end

      if (cmd.restart) begin
         hash_in  = INIT_H;
         fill_in  = '0;
         total_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= INIT_H;
         fill_ff  <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign status.fill      = fill_ff;
   assign status.total_max = &total_ff;

   assign rsp_payload.digest_word  = hash_ff[cmd.word_idx];
   assign rsp_payload.word_index   = cmd.word_idx;
   assign rsp_payload.last_word    = (cmd.word_idx == LAST_WORD);
   assign rsp_payload.length_error = ovf_ff;

`ifndef SYNTHESIS
   // The byte that completes a block must start its compression in the same cycle.
   a_full_block_loads: assert property (@(posedge clock) disable iff (reset)
      ((cmd.absorb || cmd.pad_shift) && fill_ff == LAST_FILL) |-> cmd.load_work)
      else $error("block completed without starting compression");
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (fill_ff == '0 && !ovf_ff && total_ff == '0))
      else $error("restart left message state behind");
   a_no_shift_in_round: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !(cmd.absorb || cmd.pad_shift || cmd.load_work))
      else $error("block register shifted during a round");
`endif

endmodule

### design/sha_controller.sv
`timescale 1ns / 1ps
// Controller of the SHA-256 hasher: sequences absorb, padding, rounds,
// finalization and digest output. Depends on sha_pkg.
module sha_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sha_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sha_pkg::ctl_status_type  status,
   output sha_pkg::ctl_cmd_type     cmd
);
   import sha_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FINAL = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       end_pend_ff, end_pend_in;
   logic       mark_pend_ff, mark_pend_in;
   logic       len_blk_ff, len_blk_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.word_idx  = word_ff;
      state_in      = state_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      end_pend_in   = end_pend_ff;
      mark_pend_in  = mark_pend_ff;
      len_blk_in    = len_blk_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.absorb       = req_payload.byte_valid && !status.total_max;
               cmd.overflow_set = req_payload.byte_valid && status.total_max;
               if (cmd.absorb && status.fill == LAST_FILL) begin
                  cmd.load_work = 1'b1;
                  state_in      = ST_ROUND;
                  round_in      = '0;
                  end_pend_in   = req_payload.end_of_message;
                  mark_pend_in  = 1'b1;
                  len_blk_in    = 1'b0;
               end else if (req_payload.end_of_message) begin
                  state_in     = ST_PAD;
                  end_pend_in  = 1'b1;
                  mark_pend_in = 1'b1;
                  len_blk_in   = 1'b0;
               end
            end
         end
         ST_PAD: begin
            cmd.pad_shift = 1'b1;
            cmd.pad_mark  = mark_pend_ff;
            cmd.pad_len   = len_blk_ff && !mark_pend_ff && (status.fill inside {[56:63]});
            mark_pend_in  = 1'b0;
            // The length fits in this block only if the marker lands before slot 56.
            if (mark_pend_ff && status.fill < PAD_LIMIT) begin
               len_blk_in = 1'b1;
            end
            if (status.fill == LAST_FILL) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               round_in      = '0;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            if (!end_pend_ff) begin
               state_in = ST_IDLE;
            end else if (mark_pend_ff) begin
               state_in = ST_PAD;
            end else if (len_blk_ff) begin
               state_in = ST_EMIT;
               word_in  = '0;
            end else begin
               len_blk_in = 1'b1;
               state_in   = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  end_pend_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         word_ff      <= '0;
         end_pend_ff  <= 1'b0;
         mark_pend_ff <= 1'b0;
         len_blk_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         end_pend_ff  <= end_pend_in;
         mark_pend_ff <= mark_pend_in;
         len_blk_ff   <= len_blk_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while digest is being delivered");
   a_final_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> $past(state_ff == ST_ROUND && round_ff == LAST_ROUND))
      else $error("finalization without 64 rounds");
   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && word_ff == LAST_WORD) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after the digest");
   a_emit_needs_length: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(len_blk_ff && !mark_pend_ff))
      else $error("digest emitted before the length block was compressed");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sha256_message_hasher: a directed table, then random messages.
// Depends on sha_pkg for the payload types and on the hasher RTL; the SHA-256 predictor is local.
module tb;
   import sha_pkg::*;

   localparam int ITEM_TARGET   = 430;
   localparam int HOLD_CYCLES   = 600;
   localparam int IDLE_LIMIT    = 3000;
   localparam int DRAIN_CYCLES  = 200;
   localparam int DIRECTED_ROWS = 13;

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      req_payload_type item;
      logic            typed;
      logic [255:0]    digest;
   } stim_row_type;

   // Columns: data_byte, byte_valid, end_of_message, digest typed in, digest.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      {8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'ha5, 1'b0, 1'b1, 1'b1,
       256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
      {8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h3c, 1'b0, 1'b1, 1'b0, 256'h0},
      {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h63, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h7f, 1'b1, 1'b1, 1'b0, 256'h0}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Predictor state.
   logic [31:0] hash_state [8];
   logic [7:0]  block_buf [64];
   logic [5:0]  block_fill;
   logic [60:0] msg_bytes;
   logic        len_overflow;

   rsp_payload_type expected_digest_words [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_pending = 1'b0;
   int  error_count = 0;
   int  items_sent = 0;
   int  messages_sent = 0;
   int  words_checked = 0;
   int  idle_cycles = 0;

   sha256_message_hasher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_buf[4 * i], block_buf[4 * i + 1], block_buf[4 * i + 2],
                 block_buf[4 * i + 3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
         s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
         w[i] = s1 + w[i - 7] + s0 + w[i - 16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_CONST[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   function automatic void clear_hash_state();
      for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
      block_fill   = '0;
      msg_bytes    = '0;
      len_overflow = 1'b0;
   endfunction

   // Advances the predictor by one accepted transaction; an end mark queues eight words.
   task automatic predict_item(input req_payload_type item, input logic typed,
                               input logic [255:0] typed_digest);
      int              idx;
      logic [63:0]     bit_count;
      rsp_payload_type word;
      if (item.byte_valid) begin
         if (msg_bytes == '1) begin
            len_overflow = 1'b1;
         end else begin
            msg_bytes = msg_bytes + 1'b1;
            block_buf[block_fill] = item.data_byte;
            block_fill = block_fill + 1'b1;
            if (block_fill == 6'd0) compress_block();
         end
      end
      if (item.end_of_message) begin
         idx = block_fill;
         block_buf[idx] = 8'h80;
         idx++;
         // No room for the length field: pad this block out and start another.
         if (idx > 56) begin
            while (idx < 64) begin
               block_buf[idx] = 8'h00;
               idx++;
            end
            compress_block();
            idx = 0;
         end
         while (idx < 56) begin
            block_buf[idx] = 8'h00;
            idx++;
         end
         bit_count = {msg_bytes, 3'b000};
         for (int k = 0; k < 8; k++) block_buf[63 - k] = bit_count[8 * k +: 8];
         compress_block();
         for (int k = 0; k < 8; k++) begin
            word.digest_word  = typed ? typed_digest[255 - 32 * k -: 32] : hash_state[k];
            word.word_index   = 3'(k);
            word.last_word    = (k == 7);
            word.length_error = len_overflow;
            expected_digest_words.push_back(word);
         end
         clear_hash_state();
      end
   endtask

   task automatic offer_item(input req_payload_type item, input logic typed,
                             input logic [255:0] typed_digest);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predict_item(item, typed, typed_digest);
      items_sent++;
   endtask

   // One message of random content; ignored transactions are mixed in as noise.
   task automatic send_message(input int len);
      req_payload_type item;
      bit              end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(9) == 0) begin
            item = {8'($urandom), 1'b0, 1'b0};
            offer_item(item, 1'b0, '0);
         end
         item = {8'($urandom), 1'b1, 1'(end_on_byte && n == len - 1)};
         offer_item(item, 1'b0, '0);
      end
      if (!end_on_byte) begin
         item = {8'($urandom), 1'b0, 1'b1};
         offer_item(item, 1'b0, '0);
      end
      messages_sent++;
   endtask

   function automatic void set_phase(input int phase);
      case (phase % 4)
         1: begin
            send_idle_pct = 53; stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0; stall_pct = 53;
         end
         3: begin
            send_idle_pct = 8; stall_pct = 8;
         end
         default: begin
            send_idle_pct = 0; stall_pct = 0;
         end
      endcase
   endfunction

   // Receiver stall; a requested hold keeps the result channel blocked for a long stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digest_words.size() == 0) begin
            $error("unexpected digest word transaction: %h", rsp_payload);
            error_count++;
         end else begin
            rsp_payload_type want;
            want = expected_digest_words.pop_front();
            words_checked++;
            if (rsp_payload.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, actual %h", want.digest_word,
                      rsp_payload.digest_word);
               error_count++;
            end
            if (rsp_payload.word_index !== want.word_index) begin
               $error("word_index: expected %0d, actual %0d", want.word_index,
                      rsp_payload.word_index);
               error_count++;
            end
            if (rsp_payload.last_word !== want.last_word) begin
               $error("last_word: expected %b, actual %b", want.last_word,
                      rsp_payload.last_word);
               error_count++;
            end
            if (rsp_payload.length_error !== want.length_error) begin
               $error("length_error: expected %b, actual %b", want.length_error,
                      rsp_payload.length_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("no transaction for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int len;
      int r;
      clear_hash_state();
      for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         offer_item(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].digest);
         if (DIRECTED[n].item.end_of_message) messages_sent++;
      end

      // Long output hold: the digest backs up and the input stays blocked behind it.
      set_phase(0);
      hold_pending = 1'b1;
      send_message(10);

      // Padding boundaries: length field just fits, just misses, and full blocks.
      set_phase(1);
      send_message(55);
      set_phase(2);
      send_message(56);
      set_phase(3);
      send_message(63);
      set_phase(0);
      send_message(64);

      while (items_sent < ITEM_TARGET) begin
         set_phase(messages_sent);
         r = $urandom_range(99);
         if (r < 55) len = $urandom_range(20);
         else if (r < 90) len = $urandom_range(70, 50);
         else len = $urandom_range(130, 100);
         // Keep the last message from running far past the item budget.
         if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
         send_message(len);
      end
      req_valid <= 1'b0;

      while (expected_digest_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions in %0d messages; checked %0d digest words.",
               items_sent, messages_sent, words_checked);
      $display("Covered padding boundaries, empty messages, idle and stall phases, long hold.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
